>>> hw/rtl/frjb_pkg.sv
// Shared constants, slot record type and status codes of the frame reassembly jitter buffer.
package frjb_pkg;

	localparam int TABLE_SLOTS    = 128;
	localparam int SLOT_W         = $clog2(TABLE_SLOTS);
	localparam int CNT_W          = $clog2(TABLE_SLOTS + 1);
	localparam int MAX_FRAGMENTS  = 64;
	localparam int FRAG_W         = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int TOTAL_W        = $clog2(MAX_FRAGMENTS + 1);

	localparam int HOLD_LIMIT     = 100;
	localparam int BEHIND_LIMIT   = -100;
	localparam int SKIP_LIMIT     = 100;
	localparam int US_PER_MS      = 1000;
	localparam int EARLY_COMPLETE = 3;

	// Reciprocal of 1000 scaled by 2^38; exact floor for any 32-bit dividend.
	localparam int MS_RECIP_W     = 29;
	localparam int MS_SHIFT       = 38;
	localparam int DEPTH_W        = 23;
	localparam logic [MS_RECIP_W-1:0] MS_RECIP = 29'h10624DD3;

	// Configuration register indexes.
	localparam logic REG_TARGET_DEPTH = 1'b0;
	localparam logic REG_MAX_AGE      = 1'b1;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_INVALID   = 3'd1,
		ST_TOO_OLD   = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_RELEASED  = 3'd4,
		ST_HOLDING   = 3'd5,
		ST_DROPPED   = 3'd6
	} status_t;

	typedef struct packed {
		logic [15:0]              frame;
		logic [TOTAL_W-1:0]       total;
		logic [TOTAL_W-1:0]       received;
		logic                     complete;
		logic [31:0]              arrival;
		logic [MAX_FRAGMENTS-1:0] bitmap;
	} slot_rec_t;

endpackage

>>> hw/rtl/frjb_slot_ram.sv
// Slot table memory: one write port and one registered read port.
module frjb_slot_ram (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [frjb_pkg::SLOT_W-1:0] wr_addr,
	input  frjb_pkg::slot_rec_t       wr_data,
	input  logic [frjb_pkg::SLOT_W-1:0] rd_addr,
	output frjb_pkg::slot_rec_t       rd_data
);
	import frjb_pkg::*;

	slot_rec_t mem [TABLE_SLOTS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> hw/rtl/frjb_ms_div.sv
// Microsecond to millisecond conversion by a registered reciprocal multiply.
module frjb_ms_div (
	input  logic                         clk,
	input  logic [31:0]                  age_us,
	output logic [frjb_pkg::DEPTH_W-1:0] age_ms
);
	import frjb_pkg::*;

	localparam int PROD_W = 32 + MS_RECIP_W;

	logic [PROD_W-1:0] product_s1;

	// One multiply per cycle; the quotient is the upper part of the product.
	always_ff @(posedge clk) begin
		product_s1 <= PROD_W'(age_us) * PROD_W'(MS_RECIP);
	end

	assign age_ms = product_s1[MS_SHIFT +: DEPTH_W];

endmodule

>>> hw/rtl/frame_reassembly_jitter_buffer_unit.sv
// Top level of the frame reassembly jitter buffer: sequencer and slot scan datapath.
//
// Usage: one input channel (in_valid / in_stall) carries push fragments (op 0) and pop
// requests (op 1); one output channel (out_valid / out_stall) returns exactly one result
// transfer per input transfer, in order. Configuration is written through cfg_write,
// cfg_index and cfg_data while the block is idle.
// Sequencing: every item is handled by scanning the slot table one slot per cycle through
// the single read port of the slot memory. A pop runs its scan, then the decide, divide
// and done states. A push that passes its checks runs a lookup scan, an update state, a
// statistics scan and the cut, divide and done states; a rejected push skips the lookup.
// in_stall is high from the accepting edge until the result is placed in the output
// register, so one item is in flight at a time.
// The output register holds a result while the receiver stalls; the next item is
// accepted meanwhile and waits in its last cycle until the register is free.
// Reset clears the slot valid bits, the release pointer, the start flag and the drop
// counter at once and restores the configuration defaults; no clearing pass is needed.
module frame_reassembly_jitter_buffer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [15:0] frame_id,
	input  logic [7:0]  frag_pos,
	input  logic [7:0]  frag_count,
	input  logic [31:0] now_us,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] out_frame,
	output logic [7:0]  out_total,
	output logic [15:0] dropped_now,
	output logic [31:0] dropped_total,
	output logic [7:0]  complete_frames,
	output logic [22:0] depth_ms
);
	import frjb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_UPDATE, S_STAT, S_CUT, S_POP_SCAN, S_POP_DECIDE, S_DIV, S_DONE
	} state_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  idx;
		logic [15:0]        frame;
		logic [TOTAL_W-1:0] total;
		logic               complete;
		logic [31:0]        arrival;
	} cand_t;

	// Saturating additions for the drop counters.
	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] n);
		logic [32:0] sum;
		sum = {1'b0, a} + 33'(n);
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] n);
		logic [16:0] sum;
		sum = {1'b0, a} + 17'(n);
		return sum[16] ? 16'hFFFF : sum[15:0];
	endfunction

	state_t                 state_q;
	logic [15:0]            target_q;
	logic [15:0]            max_age_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [15:0]            rp_q;
	logic                   started_q;
	logic [31:0]            drop_total_q;
	logic [15:0]            step_drops_q;
	logic [15:0]            frame_q;
	logic [7:0]             fidx_q;
	logic [TOTAL_W-1:0]     ftot_q;
	logic [31:0]            now_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   found_q;
	logic [SLOT_W-1:0]      found_idx_q;
	slot_rec_t              found_rec_q;
	logic                   free_have_q;
	logic [SLOT_W-1:0]      free_idx_q;
	logic                   expire_q;
	logic [CNT_W-1:0]       held_q;
	logic [CNT_W-1:0]       ccount_q;
	logic                   have1_q;
	logic                   have2_q;
	cand_t                  c1_q;
	cand_t                  c2_q;
	status_t                res_status_q;
	logic [15:0]            res_frame_q;
	logic [7:0]             res_total_q;
	logic                   small_have_q;
	logic [31:0]            small_arr_q;
	logic                   out_valid_q;
	logic [2:0]             status_q;
	logic [15:0]            out_frame_q;
	logic [7:0]             out_total_q;
	logic [15:0]            dropped_now_q;
	logic [31:0]            dropped_total_q;
	logic [7:0]             complete_frames_q;
	logic [22:0]            depth_ms_q;

	// Slot memory and scan addressing.
	slot_rec_t         rd_data;
	slot_rec_t         wr_rec;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	logic [SLOT_W-1:0] rd_addr;
	logic [CNT_W-1:0]  cnt_m1;
	logic [SLOT_W-1:0] idx_cur;
	logic              cur_valid;
	logic [31:0]       cur_age;
	cand_t             cur_cand;
	logic              scan_end;

	assign rd_addr   = (cnt_q < CNT_W'(TABLE_SLOTS)) ? cnt_q[SLOT_W-1:0] : '0;
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign idx_cur   = cnt_m1[SLOT_W-1:0];
	assign cur_valid = (cnt_q != '0) && valid_q[idx_cur];
	assign cur_age   = now_q - rd_data.arrival;
	assign cur_cand  = '{idx: idx_cur, frame: rd_data.frame, total: rd_data.total,
		complete: rd_data.complete, arrival: rd_data.arrival};
	assign scan_end  = (cnt_q == CNT_W'(TABLE_SLOTS));

	frjb_slot_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_rec),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Age limits in microseconds.
	logic [31:0] max_us;
	logic [31:0] tgt_us;
	logic [31:0] tgt1_us;

	assign max_us  = 32'(max_age_q) * 32'(US_PER_MS);
	assign tgt_us  = 32'(target_q) * 32'(US_PER_MS);
	assign tgt1_us = (32'(target_q) + 32'd1) * 32'(US_PER_MS);

	// Checks made on the accepted push.
	logic        push_invalid;
	logic [15:0] rp_eff;
	logic [15:0] push_delta;
	logic        push_too_old;

	assign push_invalid = (frag_count == 8'd0) ||
		(frag_count > 8'(MAX_FRAGMENTS)) || (frag_pos >= frag_count);
	assign rp_eff       = started_q ? rp_q : frame_id;
	assign push_delta   = frame_id - rp_eff;
	assign push_too_old = $signed(push_delta) < $signed(16'(BEHIND_LIMIT));

	// Expiry decision of the slot under scan.
	logic survive;
	assign survive = !(expire_q && !rd_data.complete && (cur_age > max_us));

	// Insertion of the slot under scan into the two smallest candidates.
	logic  ins_en;
	logic  n_have1;
	logic  n_have2;
	cand_t n_c1;
	cand_t n_c2;

	always_comb begin
		ins_en  = ((state_q == S_STAT) && cur_valid && survive) ||
			((state_q == S_POP_SCAN) && cur_valid);
		n_have1 = have1_q;
		n_have2 = have2_q;
		n_c1    = c1_q;
		n_c2    = c2_q;
		if (ins_en) begin
			if (!have1_q || (cur_cand.frame < c1_q.frame)) begin
				n_c2    = c1_q;
				n_have2 = have1_q;
				n_c1    = cur_cand;
				n_have1 = 1'b1;
			end else if (!have2_q || (cur_cand.frame < c2_q.frame)) begin
				n_c2    = cur_cand;
				n_have2 = 1'b1;
			end
		end
	end

	// Fragment record update after the lookup scan.
	slot_rec_t         up_base;
	slot_rec_t         up_rec;
	logic [SLOT_W-1:0] up_idx;
	logic              up_write;
	logic              up_new;
	logic              up_expire;
	status_t           up_status;
	logic [TOTAL_W-1:0] up_recv;

	always_comb begin
		up_new = !found_q;
		up_idx = found_q ? found_idx_q : free_idx_q;
		if (found_q) begin
			up_base = found_rec_q;
		end else begin
			up_base = '{frame: frame_q, total: ftot_q, received: '0, complete: 1'b0,
				arrival: now_q, bitmap: '0};
		end
		up_recv   = up_base.received + TOTAL_W'(1);
		up_rec    = up_base;
		up_write  = 1'b0;
		up_expire = 1'b0;
		up_status = ST_DUPLICATE;
		if (found_q || free_have_q) begin
			if (fidx_q >= 8'(up_base.total)) begin
				up_write  = 1'b1;
				up_expire = 1'b1;
			end else if (!up_base.bitmap[fidx_q[FRAG_W-1:0]]) begin
				up_rec.bitmap   = up_base.bitmap |
					(MAX_FRAGMENTS'(1) << fidx_q[FRAG_W-1:0]);
				up_rec.received = up_recv;
				up_rec.complete = (up_recv == up_base.total);
				up_write        = 1'b1;
				up_expire       = 1'b1;
				up_status       = ST_STORED;
			end
		end
	end

	assign wr_en   = (state_q == S_UPDATE) && up_write;
	assign wr_addr = up_idx;
	assign wr_rec  = up_rec;

	// Overflow cut after the statistics scan.
	logic cut;
	assign cut = held_q > CNT_W'(HOLD_LIMIT);

	// Pop decision on the scan results.
	logic [15:0]        skip_gap;
	logic [31:0]        skip_age;
	logic               do_skip;
	logic               s_have;
	logic [SLOT_W-1:0]  s_idx;
	logic [15:0]        s_frame;
	logic [TOTAL_W-1:0] s_total;
	logic               s_complete;
	logic [31:0]        s_age;
	logic [15:0]        rp_mid;
	status_t            pd_status;
	logic [15:0]        pd_frame;
	logic [7:0]         pd_total;
	logic               pd_free;
	logic               pd_rel;
	logic [15:0]        pd_drop_n;
	logic [15:0]        pd_rp;
	logic               pd_small_have;
	logic [31:0]        pd_small_arr;

	always_comb begin
		skip_gap = c1_q.frame - rp_q;
		skip_age = now_q - c1_q.arrival;
		do_skip  = !found_q && have1_q && (skip_gap != 16'd0) &&
			(skip_gap < 16'(SKIP_LIMIT)) && c1_q.complete && (skip_age >= tgt1_us);
		s_have   = found_q || do_skip;
		if (found_q) begin
			s_idx      = found_idx_q;
			s_frame    = found_rec_q.frame;
			s_total    = found_rec_q.total;
			s_complete = found_rec_q.complete;
			s_age      = now_q - found_rec_q.arrival;
		end else begin
			s_idx      = c1_q.idx;
			s_frame    = c1_q.frame;
			s_total    = c1_q.total;
			s_complete = c1_q.complete;
			s_age      = skip_age;
		end
		rp_mid    = do_skip ? c1_q.frame : rp_q;
		pd_status = ST_HOLDING;
		pd_frame  = rp_q;
		pd_total  = 8'd0;
		pd_free   = 1'b0;
		pd_rel    = 1'b0;
		pd_drop_n = do_skip ? skip_gap : 16'd0;
		pd_rp     = rp_mid;
		if (s_have) begin
			pd_frame = s_frame;
			if (!s_complete) begin
				if (s_age < max_us) begin
					pd_frame = rp_q;
				end else begin
					pd_drop_n = 16'd1;
					pd_free   = 1'b1;
					pd_rp     = rp_mid + 16'd1;
					pd_status = ST_DROPPED;
				end
			end else if (!((s_age < tgt_us) && (ccount_q < CNT_W'(EARLY_COMPLETE)))) begin
				pd_total  = 8'(s_total);
				pd_free   = 1'b1;
				pd_rel    = 1'b1;
				pd_rp     = rp_mid + 16'd1;
				pd_status = ST_RELEASED;
			end
		end
		if (pd_free && have1_q && (s_idx == c1_q.idx)) begin
			pd_small_have = have2_q;
			pd_small_arr  = c2_q.arrival;
		end else begin
			pd_small_have = have1_q;
			pd_small_arr  = c1_q.arrival;
		end
	end

	// Drops counted in the current cycle.
	logic [15:0] drop_n;

	always_comb begin
		unique case (state_q)
			S_STAT:       drop_n = (cur_valid && !survive) ? 16'd1 : 16'd0;
			S_CUT:        drop_n = cut ? 16'd1 : 16'd0;
			S_POP_DECIDE: drop_n = pd_drop_n;
			default:      drop_n = 16'd0;
		endcase
	end

	// Age of the smallest held frame, converted to milliseconds.
	logic [31:0]        div_in;
	logic [DEPTH_W-1:0] div_out;

	assign div_in = small_have_q ? (now_q - small_arr_q) : 32'd0;

	frjb_ms_div u_div (
		.clk    (clk),
		.age_us (div_in),
		.age_ms (div_out)
	);

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Sequencer, table state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			target_q          <= 16'd20;
			max_age_q         <= 16'd100;
			valid_q           <= '0;
			rp_q              <= '0;
			started_q         <= 1'b0;
			drop_total_q      <= '0;
			step_drops_q      <= '0;
			frame_q           <= '0;
			fidx_q            <= '0;
			ftot_q            <= '0;
			now_q             <= '0;
			cnt_q             <= '0;
			found_q           <= 1'b0;
			found_idx_q       <= '0;
			found_rec_q       <= '0;
			free_have_q       <= 1'b0;
			free_idx_q        <= '0;
			expire_q          <= 1'b0;
			held_q            <= '0;
			ccount_q          <= '0;
			have1_q           <= 1'b0;
			have2_q           <= 1'b0;
			c1_q              <= '0;
			c2_q              <= '0;
			res_status_q      <= ST_STORED;
			res_frame_q       <= '0;
			res_total_q       <= '0;
			small_have_q      <= 1'b0;
			small_arr_q       <= '0;
			out_valid_q       <= 1'b0;
			status_q          <= '0;
			out_frame_q       <= '0;
			out_total_q       <= '0;
			dropped_now_q     <= '0;
			dropped_total_q   <= '0;
			complete_frames_q <= '0;
			depth_ms_q        <= '0;
		end else begin
			// Configuration writes.
			if (cfg_write) begin
				if (cfg_index == REG_TARGET_DEPTH) begin
					target_q <= cfg_data;
				end else begin
					max_age_q <= cfg_data;
				end
			end

			// Drop accounting shared by all states; a new transfer restarts the step count.
			drop_total_q <= sat_add32(drop_total_q, drop_n);
			if ((state_q == S_IDLE) && in_valid) begin
				step_drops_q <= '0;
			end else begin
				step_drops_q <= sat_add16(step_drops_q, drop_n);
			end

			// Result transfer to the receiver; a new result may replace one that leaves.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Candidate tracking during scans; cleared while idle.
			if (state_q == S_IDLE) begin
				have1_q <= 1'b0;
				have2_q <= 1'b0;
			end else begin
				have1_q <= n_have1;
				have2_q <= n_have2;
			end
			c1_q <= n_c1;
			c2_q <= n_c2;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						frame_q      <= frame_id;
						fidx_q       <= frag_pos;
						ftot_q       <= TOTAL_W'(frag_count);
						now_q        <= now_us;
						cnt_q        <= '0;
						found_q      <= 1'b0;
						free_have_q  <= 1'b0;
						held_q       <= '0;
						ccount_q     <= '0;
						expire_q     <= 1'b0;
						res_frame_q  <= frame_id;
						res_total_q  <= 8'd0;
						if (op) begin
							state_q <= S_POP_SCAN;
						end else if (push_invalid) begin
							res_status_q <= ST_INVALID;
							state_q      <= S_STAT;
						end else begin
							if (!started_q) begin
								rp_q      <= frame_id;
								started_q <= 1'b1;
							end
							if (push_too_old) begin
								res_status_q <= ST_TOO_OLD;
								state_q      <= S_STAT;
							end else begin
								state_q <= S_FIND;
							end
						end
					end
				end

				S_FIND: begin
					cnt_q <= scan_end ? '0 : cnt_q + CNT_W'(1);
					if (cur_valid && (rd_data.frame == frame_q)) begin
						found_q     <= 1'b1;
						found_idx_q <= idx_cur;
						found_rec_q <= rd_data;
					end
					if ((cnt_q != '0) && !valid_q[idx_cur] && !free_have_q) begin
						free_have_q <= 1'b1;
						free_idx_q  <= idx_cur;
					end
					if (scan_end) begin
						state_q <= S_UPDATE;
					end
				end

				S_UPDATE: begin
					if (up_write && up_new) begin
						valid_q[up_idx] <= 1'b1;
					end
					res_status_q <= up_status;
					expire_q     <= up_expire;
					state_q      <= S_STAT;
				end

				S_STAT: begin
					cnt_q <= scan_end ? '0 : cnt_q + CNT_W'(1);
					if (cur_valid) begin
						if (survive) begin
							held_q   <= held_q + CNT_W'(1);
							ccount_q <= ccount_q + CNT_W'(rd_data.complete);
						end else begin
							valid_q[idx_cur] <= 1'b0;
						end
					end
					if (scan_end) begin
						state_q <= S_CUT;
					end
				end

				S_CUT: begin
					if (cut) begin
						valid_q[c1_q.idx] <= 1'b0;
						ccount_q          <= ccount_q - CNT_W'(c1_q.complete);
						small_have_q      <= have2_q;
						small_arr_q       <= c2_q.arrival;
					end else begin
						small_have_q <= have1_q;
						small_arr_q  <= c1_q.arrival;
					end
					state_q <= S_DIV;
				end

				S_POP_SCAN: begin
					cnt_q <= scan_end ? '0 : cnt_q + CNT_W'(1);
					if (cur_valid) begin
						ccount_q <= ccount_q + CNT_W'(rd_data.complete);
						if (rd_data.frame == rp_q) begin
							found_q     <= 1'b1;
							found_idx_q <= idx_cur;
							found_rec_q <= rd_data;
						end
					end
					if (scan_end) begin
						state_q <= S_POP_DECIDE;
					end
				end

				S_POP_DECIDE: begin
					rp_q         <= pd_rp;
					res_status_q <= pd_status;
					res_frame_q  <= pd_frame;
					res_total_q  <= pd_total;
					if (pd_free) begin
						valid_q[s_idx] <= 1'b0;
					end
					ccount_q     <= ccount_q - CNT_W'(pd_rel);
					small_have_q <= pd_small_have;
					small_arr_q  <= pd_small_arr;
					state_q      <= S_DIV;
				end

				S_DIV: begin
					state_q <= S_DONE;
				end

				S_DONE: begin
					if (out_load) begin
						status_q          <= res_status_q;
						out_frame_q       <= res_frame_q;
						out_total_q       <= res_total_q;
						dropped_now_q     <= step_drops_q;
						dropped_total_q   <= drop_total_q;
						complete_frames_q <= 8'(ccount_q);
						depth_ms_q        <= div_out;
						state_q           <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign out_frame       = out_frame_q;
	assign out_total       = out_total_q;
	assign dropped_now     = dropped_now_q;
	assign dropped_total   = dropped_total_q;
	assign complete_frames = complete_frames_q;
	assign depth_ms        = depth_ms_q;

endmodule
